FILE: rtl/sra_pkg.sv
`default_nettype none
// Package for the skyline rectangle allocator: sizes, codes, helper functions
// and the command/status structs between the controller and the datapath.
// No dependencies.
package sra_pkg;

    // Page geometry and limits.
    localparam int PAGE_WIDTH  = 128;
    localparam int PAGE_HEIGHT = 128;
    localparam int MAX_PAGES   = 128;

    // Widths of field and internal values.
    localparam int DIM_W  = 8;                          // rect_width / rect_height
    localparam int COL_W  = $clog2(PAGE_WIDTH);         // column index
    localparam int HGT_W  = $clog2(PAGE_HEIGHT + 1);    // column height
    localparam int POS_W  = 7;                          // pos_x / pos_y fields
    localparam int PAGE_W = 7;                          // page field and counter
    localparam int STAT_W = 2;                          // status field
    localparam int SUM_W  = DIM_W + 2;                  // sums of index and size
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Item commands carried in tuser.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_PLACED    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEW_PAGE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;    // latch width and height of the accepted word
        logic clear_sky;    // drop all column valid bits (skyline to zero)
        logic page_reset;   // page counter to one
        logic page_inc;     // advance the page counter
        logic prefix_init;  // start the left-to-right block prefix pass
        logic prefix_step;
        logic suffix_init;  // start the right-to-left suffix and window pass
        logic suffix_step;
        logic write_best;   // set up column writes at the chosen spot
        logic write_zero;   // set up column writes at column 0 of an empty page
        logic write_step;
        logic res_zero;     // result position 0, 0
        logic res_best;     // result position from the scan
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic size_bad;   // zero or oversized rectangle
        logic idx_first;  // scan index at column 0
        logic idx_last;   // scan index at the last column
        logic fits;       // best spot leaves room for the height
        logic page_last;  // no page left to open
        logic wr_last;    // last column write of the rectangle
    } t_dp_stat;

    // Larger of two heights.
    function automatic logic [HGT_W-1:0] f_max(input logic [HGT_W-1:0] a,
                                               input logic [HGT_W-1:0] b);
        f_max = (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sra_datapath.sv
`default_nettype none
// Datapath of the skyline rectangle allocator: skyline and block-prefix
// memories, scan pipeline, best-spot registers, column writer, page counter.
// Depends on sra_pkg.
module sra_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire sra_pkg::t_dp_cmd        i_cmd,
    input  wire [sra_pkg::DIM_W-1:0]     i_rect_width,
    input  wire [sra_pkg::DIM_W-1:0]     i_rect_height,
    output sra_pkg::t_dp_stat            o_stat,
    output logic [sra_pkg::POS_W-1:0]    o_pos_x,
    output logic [sra_pkg::POS_W-1:0]    o_pos_y,
    output logic [sra_pkg::PAGE_W-1:0]   o_page
);
    import sra_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(PAGE_WIDTH - 1);

    // Item registers.
    logic [DIM_W-1:0]  r_w;
    logic [DIM_W-1:0]  r_h;
    logic [DIM_W-1:0]  w_m1;

    // Skyline memory with per-column valid bits; an invalid column reads zero.
    logic [HGT_W-1:0]      r_hmem [PAGE_WIDTH];
    logic [PAGE_WIDTH-1:0] r_hvld;
    logic [HGT_W-1:0]      r_rd_h;
    logic                  r_rd_hv;
    logic [HGT_W-1:0]      hv;

    // Block prefix maximum memory.
    logic [HGT_W-1:0]  r_pmem [PAGE_WIDTH];
    logic [HGT_W-1:0]  r_rd_p;
    logic [COL_W-1:0]  p_rd_addr;

    // Scan control.
    logic [COL_W-1:0]  r_idx;
    logic [COL_W-1:0]  r_ph;
    logic [COL_W-1:0]  r_ph_end;
    logic [SUM_W-1:0]  win_end;
    logic              ph_at_end;

    // Stage after the memory read.
    logic              r_s1_pre;
    logic              r_s1_suf;
    logic [COL_W-1:0]  r_s1_idx;
    logic              r_s1_edge;
    logic              r_s1_win;
    logic [HGT_W-1:0]  r_run;
    logic [HGT_W-1:0]  run_next;
    logic [HGT_W-1:0]  top;

    // Best spot and writer.
    logic [HGT_W-1:0]  r_best;
    logic [COL_W-1:0]  r_best_x;
    logic [HGT_W-1:0]  r_wr_val;
    logic [DIM_W-1:0]  r_wcnt;
    logic [PAGE_W-1:0] r_page;
    logic [POS_W-1:0]  r_res_x;
    logic [POS_W-1:0]  r_res_y;
    logic [SUM_W-1:0]  fit_sum;

    // Latch the item sizes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_w <= i_rect_width;
            r_h <= i_rect_height;
        end
    end

    assign w_m1      = r_w - DIM_W'(1);
    assign ph_at_end = ({1'b0, r_ph} == w_m1);
    assign win_end   = SUM_W'(r_idx) + SUM_W'(r_w);
    assign p_rd_addr = COL_W'(win_end - SUM_W'(1));

    // Skyline memory: write port for the column writer, read port for scans.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_step) begin
            r_hmem[r_idx] <= r_wr_val;
        end
        r_rd_h <= r_hmem[r_idx];
    end

    // Valid bits: cleared together, set as columns are written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld  <= '0;
            r_rd_hv <= 1'b0;
        end else begin
            r_rd_hv <= r_hvld[r_idx];
            if (i_cmd.clear_sky) begin
                r_hvld <= '0;
            end else if (i_cmd.write_step) begin
                r_hvld[r_idx] <= 1'b1;
            end
        end
    end

    assign hv = r_rd_hv ? r_rd_h : '0;

    // Prefix memory: written by the prefix pass, read at the window's end.
    always_ff @(posedge i_clk) begin
        if (r_s1_pre) begin
            r_pmem[r_s1_idx] <= run_next;
        end
        r_rd_p <= r_pmem[p_rd_addr];
    end

    // Scan index, block phase and column writer counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.prefix_init) begin
            r_idx <= '0;
            r_ph  <= '0;
        end else if (i_cmd.prefix_step) begin
            r_idx <= r_idx + COL_W'(1);
            r_ph  <= ph_at_end ? '0 : r_ph + COL_W'(1);
            if (r_idx == LAST_COL) begin
                r_ph_end <= r_ph;
            end
        end else if (i_cmd.suffix_init) begin
            r_idx <= LAST_COL;
            r_ph  <= r_ph_end;
        end else if (i_cmd.suffix_step) begin
            r_idx <= r_idx - COL_W'(1);
            r_ph  <= (r_ph == '0) ? w_m1[COL_W-1:0] : r_ph - COL_W'(1);
        end else if (i_cmd.write_best) begin
            r_idx <= r_best_x;
        end else if (i_cmd.write_zero) begin
            r_idx <= '0;
        end else if (i_cmd.write_step) begin
            r_idx <= r_idx + COL_W'(1);
        end
    end

    // Stage control: which pass the word read this cycle belongs to.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pre <= 1'b0;
            r_s1_suf <= 1'b0;
        end else begin
            r_s1_pre <= i_cmd.prefix_step;
            r_s1_suf <= i_cmd.suffix_step;
        end
    end

    // Stage payload: block edge flag and window validity.
    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_idx;
        if (i_cmd.prefix_step) begin
            r_s1_edge <= (r_ph == '0);
        end else begin
            r_s1_edge <= (r_idx == LAST_COL) || ph_at_end;
        end
        r_s1_win <= (win_end <= SUM_W'(PAGE_WIDTH));
    end

    // Running block maximum: prefix going right, suffix going left.
    assign run_next = r_s1_edge ? hv : f_max(r_run, hv);
    assign top      = f_max(run_next, r_rd_p);

    always_ff @(posedge i_clk) begin
        if (r_s1_pre || r_s1_suf) begin
            r_run <= run_next;
        end
    end

    // Best window: scanning leftward, ties move the choice left.
    always_ff @(posedge i_clk) begin
        if (i_cmd.suffix_init) begin
            r_best   <= HGT_W'(PAGE_HEIGHT);
            r_best_x <= '0;
        end else if (r_s1_suf && r_s1_win && (top <= r_best)) begin
            r_best   <= top;
            r_best_x <= r_s1_idx;
        end
    end

    // Column writer value and count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_best) begin
            r_wr_val <= HGT_W'(fit_sum);
            r_wcnt   <= w_m1;
        end else if (i_cmd.write_zero) begin
            r_wr_val <= HGT_W'(r_h);
            r_wcnt   <= w_m1;
        end else if (i_cmd.write_step) begin
            r_wcnt <= r_wcnt - DIM_W'(1);
        end
    end

    // Page counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= PAGE_W'(1);
        end else if (i_cmd.page_reset) begin
            r_page <= PAGE_W'(1);
        end else if (i_cmd.page_inc) begin
            r_page <= r_page + PAGE_W'(1);
        end
    end

    // Result position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res_x <= '0;
            r_res_y <= '0;
        end else if (i_cmd.res_best) begin
            r_res_x <= POS_W'(r_best_x);
            r_res_y <= POS_W'(r_best);
        end
    end

    assign fit_sum = SUM_W'(r_best) + SUM_W'(r_h);

    // Status to the controller.
    always_comb begin
        o_stat.size_bad  = (r_w == '0) || (r_h == '0)
                         || (SUM_W'(r_w) > SUM_W'(PAGE_WIDTH))
                         || (SUM_W'(r_h) > SUM_W'(PAGE_HEIGHT));
        o_stat.idx_first = (r_idx == '0);
        o_stat.idx_last  = (r_idx == LAST_COL);
        o_stat.fits      = (fit_sum <= SUM_W'(PAGE_HEIGHT));
        o_stat.page_last = ((SUM_W'(r_page) + SUM_W'(1)) >= SUM_W'(MAX_PAGES));
        o_stat.wr_last   = (r_wcnt == '0);
    end

    assign o_pos_x = r_res_x;
    assign o_pos_y = r_res_y;
    assign o_page  = r_page;

endmodule
`default_nettype wire

FILE: rtl/sra_ctrl.sv
`default_nettype none
// Controller of the skyline rectangle allocator: sequences the scan passes,
// the placement decision, the column writes and the hand-off of each result.
// Depends on sra_pkg.
module sra_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_accept,
    input  wire                          i_in_command,
    input  wire                          i_out_free,
    input  wire sra_pkg::t_dp_stat       i_stat,
    output sra_pkg::t_dp_cmd             o_cmd,
    output logic                         o_ready,
    output logic                         o_out_load,
    output logic [sra_pkg::STAT_W-1:0]   o_status
);
    import sra_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_PREFIX = 4'd3;
    localparam logic [3:0] S_GAP    = 4'd4;
    localparam logic [3:0] S_SUFFIX = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_WRITE  = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;

    // Next state, status code and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_accept) begin
                    o_cmd.load_item = 1'b1;
                    n_state = (i_in_command == CMD_START) ? S_START : S_CHECK;
                end
            end
            S_START: begin
                o_cmd.clear_sky  = 1'b1;
                o_cmd.page_reset = 1'b1;
                o_cmd.res_zero   = 1'b1;
                n_status = ST_PLACED;
                n_state  = S_RESULT;
            end
            S_CHECK: begin
                if (i_stat.size_bad) begin
                    o_cmd.res_zero = 1'b1;
                    n_status = ST_TOO_LARGE;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.prefix_init = 1'b1;
                    n_state = S_PREFIX;
                end
            end
            S_PREFIX: begin
                o_cmd.prefix_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_GAP;
                end
            end
            S_GAP: begin
                // Lets the last prefix word land before the suffix pass reads it.
                o_cmd.suffix_init = 1'b1;
                n_state = S_SUFFIX;
            end
            S_SUFFIX: begin
                o_cmd.suffix_step = 1'b1;
                if (i_stat.idx_first) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.fits) begin
                    o_cmd.write_best = 1'b1;
                    o_cmd.res_best   = 1'b1;
                    n_status = ST_PLACED;
                    n_state  = S_WRITE;
                end else if (i_stat.page_last) begin
                    o_cmd.res_zero = 1'b1;
                    n_status = ST_EXHAUSTED;
                    n_state  = S_RESULT;
                end else begin
                    o_cmd.page_inc   = 1'b1;
                    o_cmd.clear_sky  = 1'b1;
                    o_cmd.write_zero = 1'b1;
                    o_cmd.res_zero   = 1'b1;
                    n_status = ST_NEW_PAGE;
                    n_state  = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_step = 1'b1;
                if (i_stat.wr_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_PLACED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_out_load = (r_state == S_RESULT) && i_out_free;
    assign o_status   = r_status;

endmodule
`default_nettype wire

FILE: rtl/skyline_rect_allocator_core.sv
`default_nettype none
// Top level of the skyline rectangle allocator: stream ports, output word
// register, controller and datapath. Depends on sra_pkg, sra_ctrl, sra_datapath.
//
// Packs rectangles into square pages of 128 by 128 and returns one result word
// for every input word. A left-to-right pass over the 128 skyline columns
// builds block prefix maxima. A right-to-left pass then finds the leftmost
// window with the lowest maximum, one column per cycle, limited by the single
// read port of each column memory. The chosen columns are then written one
// per cycle. A start word or a rejected rectangle skips the scans and goes
// straight to the result. The result sits in an output register, so the next
// word is taken while it waits to be read.
module skyline_rect_allocator_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // rect_width [7:0], rect_height [15:8]
    input  wire [sra_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // command [0]
    input  wire                                  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // pos_x [6:0], pos_y [13:7], page [20:14], zero [23:21]
    output logic [sra_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // status [1:0]
    output logic [sra_pkg::STAT_W-1:0]           m_axis_tuser
);
    import sra_pkg::*;

    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic [STAT_W-1:0] res_status;
    logic [POS_W-1:0]  res_x;
    logic [POS_W-1:0]  res_y;
    logic [PAGE_W-1:0] res_page;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic [STAT_W-1:0]      r_m_user;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_m_valid || m_axis_tready;

    sra_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_accept  (in_accept),
        .i_in_command (s_axis_tuser),
        .i_out_free   (out_free),
        .i_stat       (dp_stat),
        .o_cmd        (dp_cmd),
        .o_ready      (s_axis_tready),
        .o_out_load   (out_load),
        .o_status     (res_status)
    );

    sra_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_rect_width  (s_axis_tdata[DIM_W-1:0]),
        .i_rect_height (s_axis_tdata[2*DIM_W-1:DIM_W]),
        .o_stat        (dp_stat),
        .o_pos_x       (res_x),
        .o_pos_y       (res_y),
        .o_page        (res_page)
    );

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {(OUT_TDATA_W - 2*POS_W - PAGE_W)'(0), res_page, res_y, res_x};
            r_m_user <= res_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule
`default_nettype wire

FILE: sim/skyline_rect_allocator_core_tb.sv
`timescale 1ns / 100ps
// Testbench for skyline_rect_allocator_core: drives allocate and start words and checks
// every result word against a built-in skyline placement predictor.
// Depends on sra_pkg and the allocator RTL only.
module skyline_rect_allocator_core_tb;
    import sra_pkg::*;

    // Longest stretch without any accepted word before the run is declared hung.
    localparam int QUIET_LIMIT   = 20000;
    // Cycles the receiver holds off in one stretch to back the block up.
    localparam int HOLD_CYCLES   = 3000;
    // Cycles to let pass after the last result, more than one full allocation.
    localparam int DRAIN_CYCLES  = 600;
    localparam int RANDOM_WORDS  = 420;
    localparam int BURN_WORDS    = 132;

    // One result as the block reports it.
    typedef struct packed {
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [PAGE_W-1:0] page;
        logic [STAT_W-1:0] status;
    } t_placement;

    // One row of stimulus; a row with a typed expectation carries it in want.
    typedef struct packed {
        logic       cmd;
        logic [7:0] rect_w;
        logic [7:0] rect_h;
        bit         fixed;
        t_placement want;
    } t_stim_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [STAT_W-1:0]       m_axis_tuser;

    skyline_rect_allocator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // rect_width [7:0], rect_height [15:8]
        .s_axis_tuser  (s_axis_tuser),   // command [0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // pos_x [6:0], pos_y [13:7], page [20:14], zero [23:21]
        .m_axis_tuser  (m_axis_tuser)    // status [1:0]
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: the skyline and the page being filled.
    int          sky_height [PAGE_WIDTH];
    int          page_now;

    t_stim_word  word_table [$];
    t_placement  pending_results [$];
    int          words_sent;
    int          results_seen;
    int          error_count;
    int          quiet_cycles;
    int          status_count [4];
    int          top_page;
    bit          hold_off;

    // Places one rectangle on the predicted skyline, or starts over, and returns
    // the result word it must produce.
    function automatic t_placement place_rect(input logic cmd, input int w, input int h);
        t_placement r;
        int best;
        int best_x;
        int top;
        int x;
        int k;
        r = '0;
        if (cmd == CMD_START) begin
            foreach (sky_height[i]) sky_height[i] = 0;
            page_now = 1;
            r.page = PAGE_W'(1);
            r.status = ST_PLACED;
            return r;
        end
        r.page = page_now[PAGE_W-1:0];
        if (w == 0 || h == 0 || w > PAGE_WIDTH || h > PAGE_HEIGHT) begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        // Leftmost window with the lowest maximum; later ties do not replace it.
        best = PAGE_HEIGHT;
        best_x = 0;
        for (x = 0; x + w <= PAGE_WIDTH; x++) begin
            top = 0;
            for (k = 0; k < w; k++)
                if (sky_height[x + k] > top) top = sky_height[x + k];
            if (top < best) begin
                best = top;
                best_x = x;
            end
        end
        if (best + h <= PAGE_HEIGHT) begin
            for (k = 0; k < w; k++) sky_height[best_x + k] = best + h;
            r.pos_x = best_x[POS_W-1:0];
            r.pos_y = best[POS_W-1:0];
            r.status = ST_PLACED;
        end else if (page_now + 1 >= MAX_PAGES) begin
            r.status = ST_EXHAUSTED;
        end else begin
            // Open a fresh page; the rectangle goes to its corner.
            page_now++;
            foreach (sky_height[i]) sky_height[i] = 0;
            for (k = 0; k < w; k++) sky_height[k] = h;
            r.page = page_now[PAGE_W-1:0];
            r.status = ST_NEW_PAGE;
        end
        return r;
    endfunction

    // Appends one stimulus word, optionally with a typed expectation.
    function automatic void add_word(input logic cmd, input int w, input int h,
                                     input bit fixed, input int x, input int y,
                                     input int pg, input logic [STAT_W-1:0] st);
        t_stim_word s;
        s.cmd = cmd;
        s.rect_w = w[7:0];
        s.rect_h = h[7:0];
        s.fixed = fixed;
        s.want.pos_x = x[POS_W-1:0];
        s.want.pos_y = y[POS_W-1:0];
        s.want.page = pg[PAGE_W-1:0];
        s.want.status = st;
        word_table.push_back(s);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result word %0d: %s got %0d, expected %0d",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Directed rows first, then a page-burning run that reaches exhaustion, then
    // random words.
    initial begin : build_stimulus
        int sel;
        int w;
        int h;
        add_word(CMD_START, 0, 0, 1, 0, 0, 1, ST_PLACED);
        add_word(CMD_ALLOC, 128, 128, 1, 0, 0, 1, ST_PLACED);
        add_word(CMD_ALLOC, 1, 1, 1, 0, 0, 2, ST_NEW_PAGE);
        add_word(CMD_ALLOC, 0, 5, 1, 0, 0, 2, ST_TOO_LARGE);
        add_word(CMD_ALLOC, 5, 0, 1, 0, 0, 2, ST_TOO_LARGE);
        add_word(CMD_ALLOC, 0, 0, 1, 0, 0, 2, ST_TOO_LARGE);
        add_word(CMD_ALLOC, 129, 1, 1, 0, 0, 2, ST_TOO_LARGE);
        add_word(CMD_ALLOC, 1, 129, 1, 0, 0, 2, ST_TOO_LARGE);
        add_word(CMD_ALLOC, 255, 255, 1, 0, 0, 2, ST_TOO_LARGE);
        add_word(CMD_ALLOC, 127, 10, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_ALLOC, 1, 127, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_ALLOC, 128, 1, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_START, 255, 255, 1, 0, 0, 1, ST_PLACED);
        add_word(CMD_ALLOC, 1, 128, 1, 0, 0, 1, ST_PLACED);
        add_word(CMD_ALLOC, 128, 1, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_ALLOC, 4, 10, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_ALLOC, 4, 10, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_ALLOC, 8, 3, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_ALLOC, 64, 64, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_ALLOC, 64, 64, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_ALLOC, 2, 60, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_START, 0, 0, 1, 0, 0, 1, ST_PLACED);

        // Rectangles wider and taller than half a page each need a page of their
        // own, so this run walks the counter up to the last page and then into exhaustion.
        for (int n = 0; n < BURN_WORDS; n++)
            add_word(CMD_ALLOC, $urandom_range(65, 128), $urandom_range(65, 128),
                     0, 0, 0, 0, ST_PLACED);
        add_word(CMD_ALLOC, 1, 1, 0, 0, 0, 0, ST_PLACED);
        add_word(CMD_START, $urandom_range(0, 255), $urandom_range(0, 255),
                 0, 0, 0, 0, ST_PLACED);

        // Mostly small rectangles so pages fill up column by column.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                w = $urandom_range(0, 255);
                h = $urandom_range(0, 255);
            end else if (sel < 65) begin
                w = $urandom_range(1, 24);
                h = $urandom_range(1, 24);
            end else if (sel < 80) begin
                w = $urandom_range(1, 64);
                h = $urandom_range(1, 16);
            end else if (sel < 92) begin
                w = $urandom_range(1, 128);
                h = $urandom_range(1, 128);
            end else begin
                w = $urandom_range(0, 255);
                h = $urandom_range(0, 255);
            end
            add_word(sel < 3 ? CMD_START : CMD_ALLOC, w, h, 0, 0, 0, 0, ST_PLACED);
        end
    end

    // Both handshakes, prediction, checking and the watchdog share one process so
    // that a word is always predicted before its result can be checked.
    always @(posedge i_clk) begin : handshake
        t_placement want;
        t_placement got;
        int phase;
        int idle_pct;
        int stall_pct;
        bit moved;
        moved = 0;
        if (i_rst_n) begin
            // Input side: predict the accepted word.
            if (s_axis_tvalid && s_axis_tready) begin
                want = place_rect(word_table[words_sent].cmd,
                                  word_table[words_sent].rect_w,
                                  word_table[words_sent].rect_h);
                if (word_table[words_sent].fixed) want = word_table[words_sent].want;
                pending_results.push_back(want);
                words_sent++;
                moved = 1;
            end

            // Output side: compare against the oldest expectation.
            if (m_axis_tvalid && m_axis_tready) begin
                got.pos_x = m_axis_tdata[6:0];
                got.pos_y = m_axis_tdata[13:7];
                got.page = m_axis_tdata[20:14];
                got.status = m_axis_tuser;
                moved = 1;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word, status", got.status, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.pos_x !== want.pos_x)
                        report_mismatch("pos_x", got.pos_x, want.pos_x);
                    if (got.pos_y !== want.pos_y)
                        report_mismatch("pos_y", got.pos_y, want.pos_y);
                    if (got.page !== want.page)
                        report_mismatch("page", got.page, want.page);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (m_axis_tdata[23:21] !== 3'b000)
                        report_mismatch("pad bits", m_axis_tdata[23:21], 0);
                    status_count[want.status]++;
                    if (want.page > top_page) top_page = want.page;
                end
                results_seen++;
            end

            // Idle and stall rates move through four phases of the stimulus.
            phase = (words_sent * 4) / word_table.size();
            idle_pct = (phase == 1) ? 47 : (phase == 3) ? 28 : 0;
            stall_pct = (phase == 2) ? 47 : (phase == 3) ? 28 : 0;

            // A valid word stays up until it is taken.
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (words_sent < word_table.size() &&
                         $urandom_range(0, 99) >= idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= word_table[words_sent].cmd;
                s_axis_tdata <= {word_table[words_sent].rect_h,
                                 word_table[words_sent].rect_w};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);

            // Watchdog on cycles with no accepted word on either side.
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d idle cycles, %0d words sent, %0d results",
                         quiet_cycles, words_sent, results_seen);
                $display("skyline_rect_allocator_core_tb: done, errors");
                $finish;
            end
        end
    end

    // The receiver goes quiet for a long stretch early on while words keep coming.
    initial begin : back_pressure
        hold_off = 0;
        while (words_sent < 40) @(posedge i_clk);
        hold_off = 1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 0;
    end

    // Reset, run the stimulus, drain and judge.
    initial begin : run_test
        foreach (sky_height[i]) sky_height[i] = 0;
        page_now = 1;
        words_sent = 0;
        results_seen = 0;
        error_count = 0;
        quiet_cycles = 0;
        top_page = 0;
        foreach (status_count[i]) status_count[i] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_sent < word_table.size()) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results missing at end", 0, pending_results.size());

        $display("covered %0d words: %0d placed, %0d on a new page, %0d too large, %0d exhausted",
                 results_seen, status_count[ST_PLACED], status_count[ST_NEW_PAGE],
                 status_count[ST_TOO_LARGE], status_count[ST_EXHAUSTED]);
        $display("highest page reached %0d, idle and stall phases plus one long hold-off",
                 top_page);
        if (error_count == 0) begin
            $display("skyline_rect_allocator_core_tb: done, clean");
        end else begin
            $display("skyline_rect_allocator_core_tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sra_pkg.sv
rtl/sra_datapath.sv
rtl/sra_ctrl.sv
rtl/skyline_rect_allocator_core.sv
sim/skyline_rect_allocator_core_tb.sv
